// File: rtl/assert_macros.svh
// assertion helpers for the rtl files, included by the decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property that must hold at every rising clock edge out of reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/htd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package htd_pkg;

    localparam int SALT_MAX         = 16;
    localparam int CRYPT_HASH_BYTES = 16;
    localparam int MAX_HASH_BYTES   = 256;
    localparam int MAX_RESULTS      = 4;
    localparam int FIFO_DEPTH       = 8;

    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int PUSH_W = $clog2(MAX_RESULTS + 1);
    localparam int SALT_W = $clog2(SALT_MAX + 1);
    localparam int HPOS_W = $clog2(CRYPT_HASH_BYTES + 1);

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_PFX1  = 3'd1,
        PH_PFX2  = 3'd2,
        PH_SALT  = 3'd3,
        PH_SKIP  = 3'd4,
        PH_B64   = 3'd5,
        PH_HEX   = 3'd6,
        PH_DRAIN = 3'd7
    } t_phase;

    localparam logic [1:0] KIND_SALT   = 2'd0;
    localparam logic [1:0] KIND_HASH   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ERR_OK     = 3'd0;
    localparam logic [2:0] ERR_LENGTH = 3'd1;
    localparam logic [2:0] ERR_EMPTY  = 3'd2;
    localparam logic [2:0] ERR_PREFIX = 3'd3;
    localparam logic [2:0] ERR_HEX    = 3'd4;

    localparam logic CFG_HASH_BYTES = 1'b0;
    localparam logic CFG_SKIP_LEN   = 1'b1;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [3:0] SCRAMBLE_TAB [16] = '{
        4'd12, 4'd6, 4'd0, 4'd13, 4'd7, 4'd1, 4'd14, 4'd8,
        4'd2, 4'd15, 4'd9, 4'd3, 4'd5, 4'd10, 4'd4, 4'd11
    };

    typedef struct packed {
        logic [7:0] text_char;
        logic       final_char;
    } t_in_item;

    typedef struct packed {
        logic [1:0] item_kind;
        logic [7:0] byte_index;
        logic [7:0] byte_value;
        logic [2:0] error_code;
        logic       run_end;
    } t_out_item;

    typedef t_out_item [MAX_RESULTS-1:0] t_out_vec;

    // crypt base64 alphabet, unmapped characters give zero
    function automatic logic [5:0] b64_value(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c == 8'h2E) begin
            t = 8'd0;
        end else if (c == 8'h2F) begin
            t = 8'd1;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30 + 8'd2;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            t = c - 8'h41 + 8'd12;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            t = c - 8'h61 + 8'd38;
        end
        return t[5:0];
    endfunction

    // returns {digit ok, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] t;
        logic       ok;
        t  = 8'd0;
        ok = 1'b1;
        if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'h61 + 8'd10;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'h41 + 8'd10;
        end else begin
            ok = 1'b0;
        end
        return {ok, t[3:0]};
    endfunction

endpackage

`default_nettype wire

// File: rtl/htd_item_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module htd_item_fifo (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire [htd_pkg::PUSH_W-1:0] i_push_cnt,
    input  wire htd_pkg::t_out_vec    i_push_items,
    input  wire                       i_pop,
    output htd_pkg::t_out_item        o_head,
    output logic [htd_pkg::CNT_W-1:0] o_count
);
    import htd_pkg::*;

    t_out_item          r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    // several results of one request land in consecutive slots
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (PUSH_W'(k) < i_push_cnt) begin
                r_mem[r_wr_ptr + PTR_W'(k)] <= i_push_items[k];
            end
        end
    end

    always_comb begin
        n_count = r_count + CNT_W'(i_push_cnt) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push_cnt);
            r_rd_ptr <= r_rd_ptr + PTR_W'(i_pop);
            r_count  <= n_count;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

// File: rtl/hash_text_decoder.sv
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+---------------------------------
// in        | input     | i_in_valid / o_in_stall   | i_in_data  (text_char, final_char)
// out       | output    | o_out_valid / i_out_stall | o_out_data (kind, index, value, ...)
// cfg       | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one character is decoded per cycle while the input is not stalled; each request yields zero to four results
// results go into an eight-entry queue and leave one per cycle while i_out_stall is low
// the input stalls while fewer than four queue slots are free, so a base64
// group (three bytes per four characters) streams at one character per cycle while the receiver does not stall
// synchronous active-low reset clears text state and queue and sets the config registers to their defaults
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hash_text_decoder (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire htd_pkg::t_in_item i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output htd_pkg::t_out_item  o_out_data,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire                 i_cfg_index,
    input  wire [8:0]           i_cfg_data
);
    import htd_pkg::*;

    logic [8:0]         r_hash_bytes;
    logic               r_skip_len;

    t_phase             r_phase,     n_phase;
    logic [9:0]         r_char_cnt,  n_char_cnt;
    logic [17:0]        r_sextets,   n_sextets;
    logic [1:0]         r_fill,      n_fill;
    logic [HPOS_W-1:0]  r_hash_pos,  n_hash_pos;
    logic [SALT_W-1:0]  r_salt_len,  n_salt_len;
    logic [3:0]         r_hex_hi,    n_hex_hi;
    logic [2:0]         r_err,       n_err;

    logic               in_acc;
    logic [7:0]         c;
    logic               fin;
    logic               empty;
    logic               do_hex;
    logic               crypt_path;
    logic               flush_now;
    logic [23:0]        flush_v;
    logic [5:0]         sextet;
    logic [4:0]         hexr;
    logic [8:0]         bi;
    logic [9:0]         want;
    logic [2:0]         status_err;
    logic [PUSH_W-1:0]  nb;
    t_out_vec           slots;
    logic [PUSH_W-1:0]  push_cnt;
    logic               pop;
    logic [CNT_W-1:0]   fifo_count;
    t_out_item          head;

    assign in_acc = i_in_valid && !o_in_stall;
    assign c      = i_in_data.text_char;
    assign fin    = i_in_data.final_char;
    assign want   = {r_hash_bytes, 1'b0};
    assign sextet = b64_value(c);
    assign hexr   = hex_value(c);
    assign bi     = r_char_cnt[9:1];

    always_comb begin
        n_phase    = r_phase;
        n_char_cnt = r_char_cnt;
        n_sextets  = r_sextets;
        n_fill     = r_fill;
        n_hash_pos = r_hash_pos;
        n_salt_len = r_salt_len;
        n_hex_hi   = r_hex_hi;
        n_err      = r_err;
        slots      = '0;
        nb         = '0;
        do_hex     = 1'b0;
        flush_now  = 1'b0;
        flush_v    = '0;
        crypt_path = 1'b0;
        status_err = ERR_OK;

        empty = (r_phase == PH_START) && (c == CH_NUL) && fin;

        if (!empty) begin
            if (r_char_cnt != 10'h3FF) begin
                n_char_cnt = r_char_cnt + 10'd1;
            end
            case (r_phase)
                PH_START: begin
                    if (c == CH_DOLLAR) begin
                        n_phase = PH_PFX1;
                    end else begin
                        n_phase = PH_HEX;
                        do_hex  = 1'b1;
                    end
                end
                PH_HEX: begin
                    do_hex = 1'b1;
                end
                PH_PFX1: begin
                    if (c == CH_ONE) begin
                        n_phase = PH_PFX2;
                    end else begin
                        n_err   = ERR_PREFIX;
                        n_phase = PH_DRAIN;
                    end
                end
                PH_PFX2: begin
                    if (c == CH_DOLLAR) begin
                        n_phase = PH_SALT;
                    end else begin
                        n_err   = ERR_PREFIX;
                        n_phase = PH_DRAIN;
                    end
                end
                PH_SALT: begin
                    if (c == CH_DOLLAR) begin
                        n_phase = PH_B64;
                    end else begin
                        slots[0].item_kind  = KIND_SALT;
                        slots[0].byte_index = 8'(r_salt_len);
                        slots[0].byte_value = c;
                        nb                  = PUSH_W'(1);
                        n_salt_len          = r_salt_len + SALT_W'(1);
                        if (n_salt_len >= SALT_W'(SALT_MAX)) begin
                            n_phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    n_phase = PH_B64;
                end
                PH_B64: begin
                    if (r_fill == 2'd3) begin
                        flush_now = 1'b1;
                        flush_v   = {sextet, r_sextets};
                        n_sextets = '0;
                        n_fill    = '0;
                    end else begin
                        case (r_fill)
                            2'd0:    n_sextets[5:0]   = sextet;
                            2'd1:    n_sextets[11:6]  = sextet;
                            default: n_sextets[17:12] = sextet;
                        endcase
                        n_fill = r_fill + 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (do_hex) begin
            if (!hexr[4] && n_err == ERR_OK) begin
                n_err = ERR_HEX;
            end
            if (!r_char_cnt[0]) begin
                n_hex_hi = hexr[3:0];
            end else if (bi < r_hash_bytes && {1'b0, bi} < 10'(MAX_HASH_BYTES)) begin
                slots[0].item_kind  = KIND_HASH;
                slots[0].byte_index = bi[7:0];
                slots[0].byte_value = {r_hex_hi, hexr[3:0]};
                nb                  = PUSH_W'(1);
            end
        end

        if (fin) begin
            crypt_path = (n_phase != PH_START) && (n_phase != PH_HEX);
            if (n_phase == PH_PFX1 || n_phase == PH_PFX2) begin
                n_err = ERR_PREFIX;
            end
            // a short last group is written with zero padding
            if (n_phase == PH_B64 && n_fill != 2'd0) begin
                flush_now = 1'b1;
                flush_v   = {6'd0, n_sextets};
            end
        end

        if (flush_now) begin
            for (int j = 0; j < 3; j++) begin
                if ({1'b0, r_hash_pos} + (HPOS_W+1)'(j) < (HPOS_W+1)'(CRYPT_HASH_BYTES)) begin
                    slots[j].item_kind  = KIND_HASH;
                    slots[j].byte_index = 8'(SCRAMBLE_TAB[4'(r_hash_pos + HPOS_W'(j))]);
                    slots[j].byte_value = flush_v[8*j +: 8];
                    nb                  = PUSH_W'(j + 1);
                end
            end
            n_hash_pos = r_hash_pos + HPOS_W'(nb);
        end

        if (fin) begin
            if (!r_skip_len && n_char_cnt != want) begin
                status_err = ERR_LENGTH;
            end else if ({1'b0, r_hash_bytes} > 10'(MAX_HASH_BYTES)) begin
                status_err = ERR_LENGTH;
            end else if (empty) begin
                status_err = ERR_EMPTY;
            end else if (crypt_path) begin
                status_err = n_err;
            end else if (n_char_cnt != want) begin
                status_err = ERR_LENGTH;
            end else begin
                status_err = n_err;
            end
            slots[nb[1:0]].item_kind  = KIND_STATUS;
            slots[nb[1:0]].error_code = status_err;
            slots[nb[1:0]].run_end    = 1'b1;
            nb = nb + PUSH_W'(1);

            n_phase    = PH_START;
            n_char_cnt = '0;
            n_sextets  = '0;
            n_fill     = '0;
            n_hash_pos = '0;
            n_salt_len = '0;
            n_hex_hi   = '0;
            n_err      = ERR_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_char_cnt <= '0;
            r_sextets  <= '0;
            r_fill     <= '0;
            r_hash_pos <= '0;
            r_salt_len <= '0;
            r_hex_hi   <= '0;
            r_err      <= ERR_OK;
        end else if (in_acc) begin
            r_phase    <= n_phase;
            r_char_cnt <= n_char_cnt;
            r_sextets  <= n_sextets;
            r_fill     <= n_fill;
            r_hash_pos <= n_hash_pos;
            r_salt_len <= n_salt_len;
            r_hex_hi   <= n_hex_hi;
            r_err      <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_bytes <= 9'd16;
            r_skip_len   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HASH_BYTES: r_hash_bytes <= i_cfg_data;
                CFG_SKIP_LEN:   r_skip_len   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign push_cnt = in_acc ? nb : '0;
    assign pop      = o_out_valid && !i_out_stall;

    htd_item_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_cnt   (push_cnt),
        .i_push_items (slots),
        .i_pop        (pop),
        .o_head       (head),
        .o_count      (fifo_count)
    );

    // room for the largest burst of one request
    assign o_in_stall  = fifo_count > CNT_W'(FIFO_DEPTH - MAX_RESULTS);
    assign o_out_valid = fifo_count != '0;
    assign o_out_data  = head;
    assign o_cfg_ready = 1'b1;

    `ASSERT_NEVER(a_fifo_bound, i_clk, i_rst_n, fifo_count > CNT_W'(FIFO_DEPTH), "queue overflow")
    `ASSERT_PROP(a_final_clears, i_clk, i_rst_n, in_acc && fin |=> r_phase == PH_START && r_char_cnt == '0, "text state not cleared after final")
    `ASSERT_PROP(a_end_is_status, i_clk, i_rst_n, o_out_valid |-> ((o_out_data.item_kind == KIND_STATUS) == o_out_data.run_end), "run_end not on status item")
    `ASSERT_NEVER(a_hash_pos_bound, i_clk, i_rst_n, r_hash_pos > HPOS_W'(CRYPT_HASH_BYTES), "hash position past end")

endmodule

`default_nettype wire

// File: sim/htd_checker.sv
`timescale 1ns / 1ps

module htd_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_stall,
    input  htd_pkg::t_in_item   i_in_data,
    input  wire                 i_out_valid,
    input  wire                 i_out_stall,
    input  htd_pkg::t_out_item  i_out_data,
    input  wire                 i_cfg_valid,
    input  wire                 i_cfg_ready,
    input  wire                 i_cfg_index,
    input  wire [8:0]           i_cfg_data,
    output int                  o_mismatches,
    output int                  o_pending
);
    import htd_pkg::*;

    localparam logic [3:0] HASH_SLOT [16] = '{
        4'd12, 4'd6, 4'd0, 4'd13, 4'd7, 4'd1, 4'd14, 4'd8,
        4'd2, 4'd15, 4'd9, 4'd3, 4'd5, 4'd10, 4'd4, 4'd11
    };

    // register copies
    logic [8:0]  hash_bytes;
    logic        skip_len_check;

    // per-text decode state
    t_phase      phase_q;
    logic [9:0]  char_cnt;
    logic [17:0] sextets;
    logic [1:0]  fill;
    logic [4:0]  hash_pos;
    logic [4:0]  salt_cnt;
    logic [3:0]  high_nib;
    logic [2:0]  err_seen;

    t_out_item   decoded_items [$];
    int          mismatches = 0;

    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        // '.' and '/' run straight into the digits
        if (c >= 8'h2E && c <= 8'h39) begin
            v = c - 8'd46;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            v = c - 8'd53;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = c - 8'd59;
        end
        return v[5:0];
    endfunction

    // {digit ok, nibble}; a bad digit reads as zero
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b1, c[3:0]};
        end
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            return {1'b1, c[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

    function automatic void clear_text();
        phase_q  = PH_START;
        char_cnt = '0;
        sextets  = '0;
        fill     = '0;
        hash_pos = '0;
        salt_cnt = '0;
        high_nib = '0;
        err_seen = ERR_OK;
    endfunction

    function automatic void emit(input logic [1:0] kind, input logic [7:0] idx,
                                 input logic [7:0] val, input logic [2:0] err,
                                 input logic last);
        t_out_item it;
        it.item_kind  = kind;
        it.byte_index = idx;
        it.byte_value = val;
        it.error_code = err;
        it.run_end    = last;
        decoded_items = {decoded_items, it};
    endfunction

    function automatic void flush_group(input logic [5:0] top);
        logic [23:0] word;
        int          j;
        word = {top, sextets};
        for (j = 0; j < 3; j++) begin
            if (hash_pos < CRYPT_HASH_BYTES) begin
                emit(KIND_HASH, {4'd0, HASH_SLOT[hash_pos[3:0]]}, word[8*j +: 8], ERR_OK, 1'b0);
                hash_pos++;
            end
        end
        sextets = '0;
        fill    = '0;
    endfunction

    function automatic void take_sextet(input logic [5:0] s);
        if (fill == 2'd3) begin
            flush_group(s);
        end else begin
            sextets[6*fill +: 6] = s;
            fill++;
        end
    endfunction

    function automatic void hex_char(input logic [7:0] c, input logic [9:0] pos);
        logic [4:0] d;
        d = digit_of(c);
        if (!d[4] && err_seen == ERR_OK) begin
            err_seen = ERR_HEX;
        end
        if (!pos[0]) begin
            high_nib = d[3:0];
        end else if ((pos >> 1) < hash_bytes && (pos >> 1) < MAX_HASH_BYTES) begin
            emit(KIND_HASH, pos[8:1], {high_nib, d[3:0]}, ERR_OK, 1'b0);
        end
    endfunction

    function automatic void decode_char(input logic [7:0] c, input logic fin);
        logic       empty;
        logic       crypt;
        logic [9:0] pos;
        logic [2:0] status;
        int         want;
        empty = 1'b0;
        want  = 2 * hash_bytes;
        // a lone nul marked final stands for the empty text
        if (phase_q == PH_START && c == CH_NUL && fin) begin
            empty = 1'b1;
        end else begin
            pos = char_cnt;
            if (char_cnt != 10'd1023) begin
                char_cnt++;
            end
            case (phase_q)
                PH_START: begin
                    if (c == CH_DOLLAR) begin
                        phase_q = PH_PFX1;
                    end else begin
                        phase_q = PH_HEX;
                        hex_char(c, pos);
                    end
                end
                PH_HEX: begin
                    hex_char(c, pos);
                end
                PH_PFX1: begin
                    if (c == CH_ONE) begin
                        phase_q = PH_PFX2;
                    end else begin
                        err_seen = ERR_PREFIX;
                        phase_q  = PH_DRAIN;
                    end
                end
                PH_PFX2: begin
                    if (c == CH_DOLLAR) begin
                        phase_q = PH_SALT;
                    end else begin
                        err_seen = ERR_PREFIX;
                        phase_q  = PH_DRAIN;
                    end
                end
                PH_SALT: begin
                    if (c == CH_DOLLAR) begin
                        phase_q = PH_B64;
                    end else begin
                        emit(KIND_SALT, {3'd0, salt_cnt}, c, ERR_OK, 1'b0);
                        salt_cnt++;
                        if (salt_cnt >= SALT_MAX) begin
                            phase_q = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    phase_q = PH_B64;
                end
                PH_B64: begin
                    take_sextet(sextet_of(c));
                end
                default: begin
                end
            endcase
        end

        if (fin) begin
            crypt = (phase_q != PH_START && phase_q != PH_HEX);
            if (phase_q == PH_PFX1 || phase_q == PH_PFX2) begin
                err_seen = ERR_PREFIX;
            end
            // short last group still goes out, missing sextets as zero
            if (phase_q == PH_B64 && fill != 2'd0) begin
                flush_group(6'd0);
            end
            if (!skip_len_check && char_cnt != want) begin
                status = ERR_LENGTH;
            end else if (hash_bytes > MAX_HASH_BYTES) begin
                status = ERR_LENGTH;
            end else if (empty) begin
                status = ERR_EMPTY;
            end else if (crypt) begin
                status = err_seen;
            end else if (char_cnt != want) begin
                status = ERR_LENGTH;
            end else begin
                status = err_seen;
            end
            emit(KIND_STATUS, 8'd0, 8'd0, status, 1'b1);
            clear_text();
        end
    endfunction

    function automatic void check_result(input t_out_item got);
        t_out_item want;
        if (decoded_items.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: result with nothing pending: kind=%0d idx=%0d val=%h err=%0d end=%0d",
                         $time, got.item_kind, got.byte_index, got.byte_value,
                         got.error_code, got.run_end);
            end
        end else begin
            want = decoded_items.pop_front();
            if (got.item_kind !== want.item_kind || got.byte_index !== want.byte_index ||
                got.byte_value !== want.byte_value || got.error_code !== want.error_code ||
                got.run_end !== want.run_end) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch exp kind=%0d idx=%0d val=%h err=%0d end=%0d",
                             $time, want.item_kind, want.byte_index, want.byte_value,
                             want.error_code, want.run_end);
                    $display("%0t:          got kind=%0d idx=%0d val=%h err=%0d end=%0d",
                             $time, got.item_kind, got.byte_index, got.byte_value,
                             got.error_code, got.run_end);
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_text();
            hash_bytes     = 9'd16;
            skip_len_check = 1'b0;
            decoded_items.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_HASH_BYTES) begin
                    hash_bytes = i_cfg_data;
                end else begin
                    skip_len_check = i_cfg_data[0];
                end
            end
            // push before pop so a same-edge result still meets the oldest entry
            if (i_in_valid && !i_in_stall) begin
                decode_char(i_in_data.text_char, i_in_data.final_char);
            end
            if (i_out_valid && !i_out_stall) begin
                check_result(i_out_data);
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= decoded_items.size();
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import htd_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_item   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = 1'b0;
    logic [8:0] cfg_data = 9'd0;

    int mismatches;
    int pending;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int holdoff_req = 0;
    int holdoff_ack = 0;
    int holdoff_left = 0;
    int chars_sent = 0;
    int cur_hash_bytes = 16;

    logic [7:0] text_buf [$];
    string b64_chars = "./0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
    string hex_chars = "0123456789abcdefABCDEF";

    always #5 clk = ~clk;

    hash_text_decoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    htd_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // receiver: random stall, or a long hold-off when one is requested
    always @(posedge clk) begin
        if (holdoff_req != holdoff_ack) begin
            holdoff_ack  <= holdoff_req;
            holdoff_left <= HOLD_CYCLES;
            out_stall    <= 1'b1;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            out_stall    <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // no request moved for too long
    initial begin
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("[hash_text_decoder] ERROR");
        $finish;
    end

    function automatic void add_char(input logic [7:0] ch);
        text_buf = {text_buf, ch};
    endfunction

    task automatic send_char(input logic [7:0] c, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{text_char: c, final_char: fin};
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        chars_sent++;
    endtask

    task automatic send_text();
        int i;
        for (i = 0; i < text_buf.size(); i++) begin
            send_char(text_buf[i], i == text_buf.size() - 1);
        end
    endtask

    task automatic send_literal(input string s);
        int i;
        text_buf.delete();
        for (i = 0; i < s.len(); i++) begin
            add_char(s[i]);
        end
        send_text();
    endtask

    task automatic send_single(input logic [7:0] c);
        text_buf.delete();
        add_char(c);
        send_text();
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [8:0] hb, input logic skip);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_HASH_BYTES;
        cfg_data  <= hb;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        cfg_index <= CFG_SKIP_LEN;
        cfg_data  <= {8'd0, skip};
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        cur_hash_bytes = hb;
    endtask

    function automatic logic [7:0] salt_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        return (c == CH_DOLLAR) ? 8'h61 : c;
    endfunction

    function automatic void build_crypt();
        int n_salt;
        int n_b64;
        text_buf.delete();
        add_char(CH_DOLLAR);
        add_char(CH_ONE);
        add_char(CH_DOLLAR);
        n_salt = $urandom_range(SALT_MAX);
        repeat (n_salt) add_char(salt_char());
        // a full salt is followed by a skipped character instead of '$'
        if (n_salt < SALT_MAX) begin
            add_char(CH_DOLLAR);
        end else begin
            add_char(8'($urandom_range(255)));
        end
        n_b64 = ($urandom_range(3) == 0) ? $urandom_range(26) : 22;
        repeat (n_b64) begin
            if ($urandom_range(9) == 0) begin
                add_char(8'($urandom_range(255)));
            end else begin
                add_char(b64_chars[$urandom_range(63)]);
            end
        end
    endfunction

    function automatic void build_hex();
        int len;
        text_buf.delete();
        if (2 * cur_hash_bytes <= 48 && $urandom_range(3) != 0) begin
            len = 2 * cur_hash_bytes;
        end else begin
            len = $urandom_range(48, 1);
        end
        if (len == 0) begin
            len = 1;
        end
        repeat (len) begin
            if ($urandom_range(9) == 0) begin
                add_char(8'($urandom_range(255)));
            end else begin
                add_char(hex_chars[$urandom_range(21)]);
            end
        end
    endfunction

    function automatic void build_bad_prefix();
        int pick;
        text_buf.delete();
        add_char(CH_DOLLAR);
        repeat ($urandom_range(3)) begin
            pick = $urandom_range(2);
            if (pick == 0) begin
                add_char(CH_ONE);
            end else if (pick == 1) begin
                add_char(CH_DOLLAR);
            end else begin
                add_char(8'($urandom_range(255)));
            end
        end
    endfunction

    function automatic void build_noise();
        text_buf.delete();
        if ($urandom_range(3) == 0) begin
            add_char(CH_NUL);
        end else begin
            repeat ($urandom_range(8, 1)) add_char(8'($urandom_range(255)));
        end
    endfunction

    task automatic run_random(input int n_chars);
        int stop_at;
        int pick;
        stop_at = chars_sent + n_chars;
        while (chars_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                build_crypt();
            end else if (pick < 80) begin
                build_hex();
            end else if (pick < 90) begin
                build_bad_prefix();
            end else begin
                build_noise();
            end
            send_text();
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 19;
        recv_idle_pct <= 88;

        // one-byte hash, length checked
        write_config(9'd1, 1'b0);
        send_single(CH_NUL);
        send_literal("fF");
        send_literal("g0");
        send_single(8'hFF);
        send_literal("fF0");
        wait_drained();

        // crypt length check off: empty text, short and bad prefixes, salt and groups
        write_config(9'd16, 1'b1);
        send_single(CH_NUL);
        send_literal("$");
        send_literal("$2x");
        send_literal("$1$ab$./zZ9!A");
        wait_drained();

        write_config(9'd4, 1'b0);
        run_random(110);
        wait_drained();

        send_idle_pct = 88;
        recv_idle_pct <= 19;
        write_config(9'd16, 1'b1);
        run_random(110);

        // receiver holds off while a long hex text keeps coming
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        holdoff_req <= holdoff_req + 1;
        text_buf.delete();
        repeat (40) add_char(hex_chars[$urandom_range(21)]);
        send_text();
        wait_drained();

        write_config(9'd256, 1'b0);
        run_random(90);
        wait_drained();

        write_config(9'd511, 1'b1);
        run_random(40);
        wait_drained();

        if (mismatches == 0 && pending == 0) begin
            $display("[hash_text_decoder] OK");
        end else begin
            $display("[hash_text_decoder] ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/htd_pkg.sv
rtl/htd_item_fifo.sv
rtl/hash_text_decoder.sv
sim/htd_checker.sv
sim/tb.sv
